>>> src/apm_pkg.sv
// Shared types and constants for the adaptive palette mapper.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.

package apm_pkg;

   localparam int DEFAULT_ENTRIES = 256;
   localparam int COLOR_W         = 8;
   localparam int RGB_W           = 3 * COLOR_W;
   localparam int SQUARE_W        = 2 * COLOR_W;
   localparam int DIST_W          = SQUARE_W + 2;
   localparam int INDEX_W         = 8;
   localparam int KIND_W          = 2;

   typedef enum logic [KIND_W-1:0] {
      MATCH_EXACT   = 2'd0,
      MATCH_NEW     = 2'd1,
      MATCH_NEAREST = 2'd2
   } match_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_DRAIN  = 2'd2
   } ctrl_state_type;

   // Pixel traveling down the cell row with the best candidate found so far.
   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               row_end;
      logic [DIST_W-1:0]  best_dist;
      logic [INDEX_W-1:0] best_index;
   } pixel_token_type;

   // Palette write broadcast from the controller to the cell row.
   typedef struct packed {
      logic               enable;
      logic [INDEX_W-1:0] index;
      logic [RGB_W-1:0]   color;
   } palette_write_type;

endpackage

>>> src/apm_if.sv
// Handshake channels of the adaptive palette mapper: pixel words in, index words out.
// Depends on apm_pkg for field widths.

interface apm_req_if;
   logic                        valid;
   logic                        ready;
   logic [apm_pkg::COLOR_W-1:0] pixel_red;
   logic [apm_pkg::COLOR_W-1:0] pixel_green;
   logic [apm_pkg::COLOR_W-1:0] pixel_blue;
   logic                        row_end;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, row_end, input ready);
   modport sink (input valid, pixel_red, pixel_green, pixel_blue, row_end, output ready);
endinterface

interface apm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [apm_pkg::INDEX_W-1:0] palette_index;
   logic [apm_pkg::KIND_W-1:0]  match_kind;
   logic                        row_end_out;

   modport source (output valid, palette_index, match_kind, row_end_out, input ready);
   modport sink (input valid, palette_index, match_kind, row_end_out, output ready);
endinterface

>>> src/apm_cell.sv
// One palette cell: holds one entry, scores the passing pixel against it
// and hands the token to the next cell. Depends on apm_pkg.

module apm_cell #(
   parameter int CELL_INDEX = 0,
   parameter int COUNT_W    = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [COUNT_W-1:0]         entry_count,
   input  apm_pkg::palette_write_type wr,
   input  logic                       tok_valid_in,
   input  apm_pkg::pixel_token_type   tok_in,
   output logic                       tok_valid_out,
   output apm_pkg::pixel_token_type   tok_out
);

   logic [apm_pkg::RGB_W-1:0]    entry_ff;
   logic                         tok_valid_ff;
   apm_pkg::pixel_token_type     tok_ff;
   apm_pkg::pixel_token_type     tok_in_next;

   logic                         filled;
   logic [apm_pkg::COLOR_W-1:0]  diff_r;
   logic [apm_pkg::COLOR_W-1:0]  diff_g;
   logic [apm_pkg::COLOR_W-1:0]  diff_b;
   logic [apm_pkg::SQUARE_W-1:0] sq_r;
   logic [apm_pkg::SQUARE_W-1:0] sq_g;
   logic [apm_pkg::SQUARE_W-1:0] sq_b;
   logic [apm_pkg::DIST_W-1:0]   distance;

   function automatic logic [apm_pkg::COLOR_W-1:0] abs_diff(
      input logic [apm_pkg::COLOR_W-1:0] a,
      input logic [apm_pkg::COLOR_W-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign filled = entry_count > COUNT_W'(CELL_INDEX);

   assign diff_r = abs_diff(tok_in.red,   entry_ff[3*apm_pkg::COLOR_W-1 -: apm_pkg::COLOR_W]);
   assign diff_g = abs_diff(tok_in.green, entry_ff[2*apm_pkg::COLOR_W-1 -: apm_pkg::COLOR_W]);
   assign diff_b = abs_diff(tok_in.blue,  entry_ff[apm_pkg::COLOR_W-1:0]);

   assign sq_r = diff_r * diff_r;
   assign sq_g = diff_g * diff_g;
   assign sq_b = diff_b * diff_b;
   assign distance = apm_pkg::DIST_W'(sq_r) + apm_pkg::DIST_W'(sq_g)
                   + apm_pkg::DIST_W'(sq_b);

   // Strict less-than keeps the lower index on a tie.
   always_comb begin
      tok_in_next = tok_in;
      if (filled && (distance < tok_in.best_dist)) begin
         tok_in_next.best_dist  = distance;
         tok_in_next.best_index = apm_pkg::INDEX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_next;
      if (wr.enable && (wr.index == apm_pkg::INDEX_W'(CELL_INDEX))) begin
         entry_ff <= wr.color;
      end
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_out       = tok_ff;

endmodule

>>> src/apm_ctrl.sv
// Controller: entry count, item sequencing, palette append and result registers.
// Depends on apm_pkg and apm_rsp_if.

module apm_ctrl #(
   parameter int PALETTE_ENTRIES = apm_pkg::DEFAULT_ENTRIES,
   parameter int COUNT_W         = $clog2(PALETTE_ENTRIES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       tail_valid,
   input  apm_pkg::pixel_token_type   tail_tok,
   output logic [COUNT_W-1:0]         entry_count,
   output apm_pkg::palette_write_type wr,
   apm_rsp_if.source                  rsp
);

   apm_pkg::ctrl_state_type state_ff;
   apm_pkg::ctrl_state_type state_in;

   logic [COUNT_W-1:0]          entry_count_ff;
   logic [COUNT_W-1:0]          entry_count_in;

   logic [apm_pkg::INDEX_W-1:0] hold_index_ff;
   apm_pkg::match_kind_type     hold_kind_ff;
   logic                        hold_row_end_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [apm_pkg::INDEX_W-1:0] rsp_index_ff;
   apm_pkg::match_kind_type     rsp_kind_ff;
   logic                        rsp_row_end_ff;

   logic                        capture;
   logic                        load_out;
   logic                        found;
   logic                        has_room;
   logic                        append;
   logic [apm_pkg::INDEX_W-1:0] result_index;
   apm_pkg::match_kind_type     result_kind;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apm_pkg::ST_IDLE: begin
            if (req_valid) state_in = apm_pkg::ST_SEARCH;
         end
         apm_pkg::ST_SEARCH: begin
            if (tail_valid) state_in = apm_pkg::ST_DRAIN;
         end
         apm_pkg::ST_DRAIN: begin
            if (!rsp_valid_ff || rsp.ready) state_in = apm_pkg::ST_IDLE;
         end
         default: state_in = apm_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      capture   = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         apm_pkg::ST_IDLE:   req_ready = 1'b1;
         apm_pkg::ST_SEARCH: capture   = tail_valid;
         apm_pkg::ST_DRAIN:  load_out  = !rsp_valid_ff || rsp.ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // A zero distance can only come from a filled entry, since the search starts at all ones.
   assign found    = tail_tok.best_dist == '0;
   assign has_room = entry_count_ff < COUNT_W'(PALETTE_ENTRIES);
   assign append   = capture && !found && has_room;

   always_comb begin
      if (found) begin
         result_kind  = apm_pkg::MATCH_EXACT;
         result_index = tail_tok.best_index;
      end else if (has_room) begin
         result_kind  = apm_pkg::MATCH_NEW;
         result_index = apm_pkg::INDEX_W'(entry_count_ff);
      end else begin
         result_kind  = apm_pkg::MATCH_NEAREST;
         result_index = tail_tok.best_index;
      end
   end

   assign entry_count_in = append ? entry_count_ff + COUNT_W'(1) : entry_count_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= apm_pkg::ST_IDLE;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         hold_index_ff   <= result_index;
         hold_kind_ff    <= result_kind;
         hold_row_end_ff <= tail_tok.row_end;
      end
      if (load_out) begin
         rsp_index_ff   <= hold_index_ff;
         rsp_kind_ff    <= hold_kind_ff;
         rsp_row_end_ff <= hold_row_end_ff;
      end
   end

   assign wr.enable = append;
   assign wr.index  = apm_pkg::INDEX_W'(entry_count_ff);
   assign wr.color  = {tail_tok.red, tail_tok.green, tail_tok.blue};

   assign entry_count       = entry_count_ff;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.palette_index = rsp_index_ff;
   assign rsp.match_kind    = rsp_kind_ff;
   assign rsp.row_end_out   = rsp_row_end_ff;

endmodule

>>> src/adaptive_palette_mapper.sv
// Adaptive palette mapper: a pixel word (8-bit red, green, blue and a row-end flag)
// is looked up in a palette of up to PALETTE_ENTRIES colors held in a row of cells,
// one entry per cell. The pixel walks the row one cell per clock, keeping the
// closest entry so far (squared RGB distance, lowest index on a tie). At the end of
// the row it yields an exact match, or, while the palette has room, becomes a new
// entry, or else maps to the nearest entry. One pixel is in flight at a time:
// after accept it passes every cell, the controller's hold registers and then the
// result registers, and the next pixel is accepted once the result word is loaded,
// even while the result still waits to be taken. A pixel whose search ends while
// the previous result word is still untaken waits in the controller until that
// word is taken. Reset empties the palette at once. Depends on apm_pkg, apm_if,
// apm_cell and apm_ctrl.

module adaptive_palette_mapper #(
   parameter int PALETTE_ENTRIES = apm_pkg::DEFAULT_ENTRIES
) (
   input logic       clock,
   input logic       reset,
   apm_req_if.sink   req_bus,
   apm_rsp_if.source rsp_bus
);

   localparam int COUNT_W = $clog2(PALETTE_ENTRIES + 1);

   logic                       req_accept;
   logic [COUNT_W-1:0]         entry_count;
   apm_pkg::palette_write_type wr;
   logic                       tok_valid [PALETTE_ENTRIES+1];
   apm_pkg::pixel_token_type   tok       [PALETTE_ENTRIES+1];

   assign req_accept = req_bus.valid && req_bus.ready;

   // Launch the pixel with a worst-possible candidate.
   assign tok_valid[0]        = req_accept;
   assign tok[0].red          = req_bus.pixel_red;
   assign tok[0].green        = req_bus.pixel_green;
   assign tok[0].blue         = req_bus.pixel_blue;
   assign tok[0].row_end      = req_bus.row_end;
   assign tok[0].best_dist    = '1;
   assign tok[0].best_index   = '0;

   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      apm_cell #(
         .CELL_INDEX (i),
         .COUNT_W    (COUNT_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .entry_count   (entry_count),
         .wr            (wr),
         .tok_valid_in  (tok_valid[i]),
         .tok_in        (tok[i]),
         .tok_valid_out (tok_valid[i+1]),
         .tok_out       (tok[i+1])
      );
   end

   apm_ctrl #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .COUNT_W         (COUNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .tail_valid  (tok_valid[PALETTE_ENTRIES]),
      .tail_tok    (tok[PALETTE_ENTRIES]),
      .entry_count (entry_count),
      .wr          (wr),
      .rsp         (rsp_bus)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking bench for adaptive_palette_mapper: drives pixel words, predicts each index word.
// Depends on apm_pkg, apm_if and the mapper RTL; holds its own palette predictor in a class.
`timescale 1ns / 100ps

module tb_top;
   import apm_pkg::*;

   localparam int          ENTRIES       = DEFAULT_ENTRIES;
   localparam int          RANDOM_PIXELS = 1388;
   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int          LONG_HOLD     = 3000;

   typedef struct {
      logic [INDEX_W-1:0] index;
      match_kind_type     kind;
      logic               row_end;
   } index_word_type;

   // Tracks the palette as the block should build it and checks each index word.
   class palette_tracker;
      logic [RGB_W-1:0] colors [ENTRIES];
      int unsigned      filled;
      int unsigned      fail_count;
      index_word_type   pending_words [$];

      function new();
         filled     = 0;
         fail_count = 0;
      endfunction

      function int unsigned pending();
         return pending_words.size();
      endfunction

      function logic [RGB_W-1:0] entry(int unsigned i);
         return colors[i];
      endfunction

      function logic [SQUARE_W-1:0] square_diff(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
         logic [COLOR_W-1:0] d;
         d = (a > b) ? a - b : b - a;
         return d * d;
      endfunction

      function void note_pixel(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                               logic [COLOR_W-1:0] b, logic row_end);
         index_word_type    w;
         logic [RGB_W-1:0]  color;
         logic [DIST_W-1:0] distance;
         logic [DIST_W-1:0] best_dist;
         bit                hit;
         color     = {r, g, b};
         hit       = 1'b0;
         w.index   = '0;
         w.row_end = row_end;
         for (int unsigned i = 0; i < filled && !hit; i++) begin
            if (colors[i] == color) begin
               hit     = 1'b1;
               w.index = i[INDEX_W-1:0];
            end
         end
         if (hit) begin
            w.kind = MATCH_EXACT;
         end else if (filled < ENTRIES) begin
            colors[filled] = color;
            w.index        = filled[INDEX_W-1:0];
            w.kind         = MATCH_NEW;
            filled++;
         end else begin
            // strict compare keeps the lowest index on a tie
            best_dist = '1;
            for (int unsigned i = 0; i < filled; i++) begin
               distance = DIST_W'(square_diff(r, colors[i][23:16]))
                        + DIST_W'(square_diff(g, colors[i][15:8]))
                        + DIST_W'(square_diff(b, colors[i][7:0]));
               if (distance < best_dist) begin
                  best_dist = distance;
                  w.index   = i[INDEX_W-1:0];
               end
            end
            w.kind = MATCH_NEAREST;
         end
         pending_words.push_back(w);
      endfunction

      function void check_word(logic [INDEX_W-1:0] index, logic [KIND_W-1:0] kind,
                               logic row_end);
         index_word_type w;
         if (pending_words.size() == 0) begin
            $error("index word %0d with no pixel outstanding", index);
            fail_count++;
            return;
         end
         w = pending_words.pop_front();
         if (index !== w.index) begin
            $error("palette_index: expected %0d, actual %0d", w.index, index);
            fail_count++;
         end
         if (kind !== w.kind) begin
            $error("match_kind: expected %0d, actual %0d", w.kind, kind);
            fail_count++;
         end
         if (row_end !== w.row_end) begin
            $error("row_end_out: expected %0d, actual %0d", w.row_end, row_end);
            fail_count++;
         end
      endfunction
   endclass

   logic           clock;
   logic           reset;
   int unsigned    cycle_count = 0;
   bit             send_idle_on;
   palette_tracker tracker = new();

   apm_req_if pixel_bus ();
   apm_rsp_if index_bus ();

   adaptive_palette_mapper #(
      .PALETTE_ENTRIES(ENTRIES)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (pixel_bus),
      .rsp_bus (index_bus)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offer one pixel word and hold it until the block takes it.
   task automatic send_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b, input logic row_end);
      int unsigned gap;
      gap = send_idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         pixel_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pixel_bus.valid       <= 1'b1;
      pixel_bus.pixel_red   <= r;
      pixel_bus.pixel_green <= g;
      pixel_bus.pixel_blue  <= b;
      pixel_bus.row_end     <= row_end;
      do @(posedge clock); while (!pixel_bus.ready);
      tracker.note_pixel(r, g, b, row_end);
   endtask

   function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
      int v;
      v = int'(c) + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[COLOR_W-1:0];
   endfunction

   // Mostly stored colors and near misses; a coarse grid makes distance ties common
   // once the palette is full, since odd grid steps sit halfway between entries.
   task automatic pick_pixel(output logic [COLOR_W-1:0] r, output logic [COLOR_W-1:0] g,
                             output logic [COLOR_W-1:0] b);
      int unsigned      roll;
      int unsigned      span;
      logic [RGB_W-1:0] e;
      roll = $urandom_range(0, 99);
      span = (tracker.filled < ENTRIES) ? 7 : 14;
      e    = (tracker.filled > 0) ? tracker.entry($urandom_range(0, tracker.filled - 1)) : '0;
      if (tracker.filled > 0 && roll < 30) begin
         {r, g, b} = e;
      end else if (tracker.filled > 0 && roll < 50) begin
         r = nudge(e[23:16]);
         g = nudge(e[15:8]);
         b = nudge(e[7:0]);
      end else if (roll < 75) begin
         r = COLOR_W'((span == 7) ? 36 * $urandom_range(0, 7) : 18 * $urandom_range(0, 14));
         g = COLOR_W'((span == 7) ? 36 * $urandom_range(0, 7) : 18 * $urandom_range(0, 14));
         b = COLOR_W'((span == 7) ? 36 * $urandom_range(0, 7) : 18 * $urandom_range(0, 14));
      end else begin
         r = COLOR_W'($urandom_range(0, 255));
         g = COLOR_W'($urandom_range(0, 255));
         b = COLOR_W'($urandom_range(0, 255));
      end
   endtask

   initial begin : index_sink
      int unsigned taken;
      int unsigned stall;
      bit          stall_on;
      taken    = 0;
      stall_on = 1'b1;
      index_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (taken % 97 == 0) stall_on = ($urandom_range(0, 2) != 0);
         // hold off long enough for the sender to back up behind the block
         if (taken == 200) stall = LONG_HOLD;
         else stall = stall_on ? $urandom_range(0, 17) : 0;
         if (stall > 0) begin
            index_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         index_bus.ready <= 1'b1;
         do @(posedge clock); while (!index_bus.valid);
         tracker.check_word(index_bus.palette_index, index_bus.match_kind,
                            index_bus.row_end_out);
         taken++;
      end
   end

   initial begin : pixel_source
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
      reset                 <= 1'b1;
      send_idle_on          = 1'b1;
      pixel_bus.valid       <= 1'b0;
      pixel_bus.pixel_red   <= '0;
      pixel_bus.pixel_green <= '0;
      pixel_bus.pixel_blue  <= '0;
      pixel_bus.row_end     <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes, exact repeats, single-channel colors, alternating bits
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b1);
      send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n % 128 == 0) send_idle_on = ($urandom_range(0, 3) != 0);
         if (n == 650) begin
            // drain completely before going on
            pixel_bus.valid <= 1'b0;
            while (tracker.pending() != 0) @(posedge clock);
         end
         pick_pixel(r, g, b);
         send_pixel(r, g, b, $urandom_range(0, 3) == 0);
      end
      pixel_bus.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (2 * ENTRIES) @(posedge clock);
      if (tracker.fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
